[rtl/bracket_aware_token_skipper_assert.svh]
// Assertion macros for the token skipper.
// Each check samples on the rising edge of clk and is off while rst is high.
`ifndef BRACKET_AWARE_TOKEN_SKIPPER_ASSERT_SVH
`define BRACKET_AWARE_TOKEN_SKIPPER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define BATS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bats check failed");

// Next-cycle implication
`define BATS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bats check failed");

`else

`define BATS_ASSERT_NOW(lbl, ante, cons)
`define BATS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/bats_pkg.sv]
package bats_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int KIND_W      = 2;
  localparam int CLS_W       = 3;
  localparam int OUTCOME_W   = 3;
  localparam int DEPTH_W     = 5;

  // Bracket classes of an incoming token
  localparam logic [CLS_W-1:0] CLS_NONE          = 3'd0;
  localparam logic [CLS_W-1:0] CLS_OPEN_PAREN    = 3'd1;
  localparam logic [CLS_W-1:0] CLS_OPEN_BRACE    = 3'd3;
  localparam logic [CLS_W-1:0] CLS_CLOSE_PAREN   = 3'd4;
  localparam logic [CLS_W-1:0] CLS_CLOSE_BRACE   = 3'd6;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [PTR_W-1:0]  ptr_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_CONSUMED    = 3'd0,
    OUT_MATCHED     = 3'd1,
    OUT_FOREIGN     = 3'd2,
    OUT_UNCLOSED    = 3'd3,
    OUT_REACHED_END = 3'd4,
    OUT_OVERFLOW    = 3'd5
  } outcome_t;

  // Shift command handed down the cell chain
  typedef struct packed {
    logic  push;
    logic  pop;
    kind_t push_kind;
  } bats_op_t;

endpackage

[rtl/bats_if.sv]
// Token channel
interface bats_tok_if;
  import bats_pkg::*;
  logic             valid;
  logic             ready;
  logic [CLS_W-1:0] bracket_class;
  logic             is_stop;
  logic             end_of_stream;

  modport source (output valid, bracket_class, is_stop, end_of_stream, input ready);
  modport sink   (input valid, bracket_class, is_stop, end_of_stream, output ready);
endinterface

// Result channel
interface bats_res_if;
  import bats_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [DEPTH_W-1:0]   nest_depth;
  logic                 finished;

  modport source (output valid, outcome, nest_depth, finished, input ready);
  modport sink   (input valid, outcome, nest_depth, finished, output ready);
endinterface

[rtl/bats_cell.sv]
module bats_cell
  import bats_pkg::*;
(
  input  logic     clk,
  input  bats_op_t op,
  input  kind_t    up_kind,
  input  kind_t    down_kind,
  output kind_t    kind
);

  // Shift down on push, up on pop, else hold
  always_ff @(posedge clk) begin
    if (op.push) begin
      kind <= up_kind;
    end else if (op.pop) begin
      kind <= down_kind;
    end
  end

endmodule

[rtl/bats_ctrl.sv]
module bats_ctrl
  import bats_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  bats_tok_if.sink        tok,
  bats_res_if.source      res,
  input  kind_t           top_kind,
  output bats_op_t        op,
  output ptr_t            sp,
  output logic            accept
);

  ptr_t     sp_next;
  outcome_t outcome_next;
  logic     finish;
  logic     is_closer;
  logic     is_opener;
  logic     empty;
  kind_t    closer_kind;
  kind_t    opener_kind;

  // Take a word whenever the result register is free or draining
  assign tok.ready = !res.valid || res.ready;
  assign accept    = tok.valid && tok.ready;

  assign is_closer   = (tok.bracket_class >= CLS_CLOSE_PAREN) &&
                       (tok.bracket_class <= CLS_CLOSE_BRACE);
  assign is_opener   = (tok.bracket_class >= CLS_OPEN_PAREN) &&
                       (tok.bracket_class <= CLS_OPEN_BRACE);
  assign empty       = (sp == '0);
  assign closer_kind = KIND_W'(tok.bracket_class - CLS_CLOSE_PAREN);
  assign opener_kind = KIND_W'(tok.bracket_class - CLS_OPEN_PAREN);

  // Decode the token against the stack top
  always_comb begin
    op.push      = 1'b0;
    op.pop       = 1'b0;
    op.push_kind = opener_kind;
    outcome_next = OUT_CONSUMED;
    finish       = 1'b0;
    if (tok.end_of_stream) begin
      outcome_next = empty ? OUT_REACHED_END : OUT_UNCLOSED;
      finish       = 1'b1;
    end else if (is_closer) begin
      if (!empty && top_kind == closer_kind) begin
        op.pop = accept;
      end else if (empty && tok.is_stop) begin
        outcome_next = OUT_MATCHED;
        finish       = 1'b1;
      end else begin
        outcome_next = OUT_FOREIGN;
        finish       = 1'b1;
      end
    end else if (empty && tok.is_stop) begin
      outcome_next = OUT_MATCHED;
      finish       = 1'b1;
    end else if (is_opener) begin
      if (sp == PTR_W'(STACK_DEPTH)) begin
        outcome_next = OUT_OVERFLOW;
        finish       = 1'b1;
      end else begin
        op.push = accept;
      end
    end
  end

  // Advance the stack pointer; any final outcome empties the stack
  always_comb begin
    sp_next = sp;
    if (accept) begin
      if (finish) begin
        sp_next = '0;
      end else if (op.push) begin
        sp_next = sp + PTR_W'(1);
      end else if (op.pop) begin
        sp_next = sp - PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else begin
      sp <= sp_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.outcome    <= outcome_next;
      res.nest_depth <= DEPTH_W'(sp_next);
      res.finished   <= finish;
    end
  end

endmodule

[rtl/bracket_aware_token_skipper.sv]
// Channel  Role    Fields
// tok      sink    bracket_class[2:0], is_stop, end_of_stream
// res      source  outcome[2:0], nest_depth[4:0], finished
//
// One token word per cycle when tok.ready is high; result valid the next cycle.
// The rate is set by the stack-top compare and pointer update in the control.
// rst (synchronous) empties the stack and drops any pending result word.
// tok.ready falls only while a result word waits and res.ready is low.
`include "bracket_aware_token_skipper_assert.svh"

module bracket_aware_token_skipper
  import bats_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  bats_tok_if.sink   tok,
  bats_res_if.source res
);

  bats_op_t op;
  ptr_t     sp;
  logic     accept;
  kind_t    kind [STACK_DEPTH];

  bats_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .tok      (tok),
    .res      (res),
    .top_kind (kind[0]),
    .op       (op),
    .sp       (sp),
    .accept   (accept)
  );

  // Cell chain: cell 0 holds the stack top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_t up_kind;
    kind_t down_kind;
    if (i == 0) begin : g_first
      assign up_kind = op.push_kind;
    end else begin : g_mid_up
      assign up_kind = kind[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_kind = kind[i];
    end else begin : g_mid_down
      assign down_kind = kind[i+1];
    end
    bats_cell u_cell (
      .clk       (clk),
      .op        (op),
      .up_kind   (up_kind),
      .down_kind (down_kind),
      .kind      (kind[i])
    );
  end

  `BATS_ASSERT_NOW(a_sp_bound, 1'b1, sp <= PTR_W'(STACK_DEPTH))
  `BATS_ASSERT_NOW(a_final_empty, res.valid && res.finished, res.nest_depth == '0)
  `BATS_ASSERT_NOW(a_no_both, 1'b1, !(op.push && op.pop))
  `BATS_ASSERT_NEXT(a_push_grows, op.push, sp == $past(sp) + PTR_W'(1))
  `BATS_ASSERT_NEXT(a_take_shows, accept, res.valid)

endmodule

[tb/nesting_checker.sv]
`timescale 1ns / 100ps

module nesting_checker
  import bats_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bats_tok_if         tok,
  bats_res_if         res,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct {
    outcome_t           outcome;
    logic [DEPTH_W-1:0] depth;
    logic               finished;
  } skip_word_t;

  skip_word_t  awaited_words [$];
  kind_t       closer_kinds [STACK_DEPTH];
  int unsigned nest_count;
  int unsigned word_index;

  initial begin
    fail_count = 0;
    pending    = 0;
    nest_count = 0;
    word_index = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: result word %0d: %s", $time, word_index, what);
    fail_count++;
  endtask

  // Follow the bracket nesting for one token and queue the word it must produce
  task automatic track_nesting(input logic [CLS_W-1:0] cls, input logic stop,
                               input logic eos);
    skip_word_t w;
    kind_t      want_kind;
    w.outcome  = OUT_CONSUMED;
    w.finished = 1'b0;
    if (eos) begin
      w.outcome  = (nest_count != 0) ? OUT_UNCLOSED : OUT_REACHED_END;
      w.finished = 1'b1;
    end else if (cls >= CLS_CLOSE_PAREN && cls <= CLS_CLOSE_BRACE) begin
      want_kind = kind_t'(cls - CLS_CLOSE_PAREN);
      if (nest_count != 0 && closer_kinds[nest_count-1] == want_kind) begin
        nest_count--;
      end else begin
        w.outcome  = (nest_count == 0 && stop) ? OUT_MATCHED : OUT_FOREIGN;
        w.finished = 1'b1;
      end
    end else if (nest_count == 0 && stop) begin
      w.outcome  = OUT_MATCHED;
      w.finished = 1'b1;
    end else if (cls >= CLS_OPEN_PAREN && cls <= CLS_OPEN_BRACE) begin
      if (nest_count >= STACK_DEPTH) begin
        w.outcome  = OUT_OVERFLOW;
        w.finished = 1'b1;
      end else begin
        closer_kinds[nest_count] = kind_t'(cls - CLS_OPEN_PAREN);
        nest_count++;
      end
    end
    // a final outcome always leaves the stack empty
    if (w.finished) begin
      nest_count = 0;
    end
    w.depth = DEPTH_W'(nest_count);
    awaited_words = {awaited_words, w};
  endtask

  always @(posedge clk) begin
    skip_word_t want;
    if (rst) begin
      awaited_words.delete();
      nest_count = 0;
    end else begin
      // compare the result word with the oldest prediction
      if (res.valid && res.ready) begin
        if (awaited_words.size() == 0) begin
          report_mismatch("word arrived with nothing awaited");
        end else begin
          want = awaited_words.pop_front();
          if (res.outcome !== want.outcome) begin
            report_mismatch($sformatf("outcome %0d, expected %0d",
                                      res.outcome, want.outcome));
          end
          if (res.nest_depth !== want.depth) begin
            report_mismatch($sformatf("nest_depth %0d, expected %0d",
                                      res.nest_depth, want.depth));
          end
          if (res.finished !== want.finished) begin
            report_mismatch($sformatf("finished %0d, expected %0d",
                                      res.finished, want.finished));
          end
        end
        word_index++;
      end
      // predict the word for a token taken at this edge
      if (tok.valid && tok.ready) begin
        track_nesting(tok.bracket_class, tok.is_stop, tok.end_of_stream);
      end
    end
    pending <= awaited_words.size();
  end

endmodule

[tb/tb_bracket_aware_token_skipper.sv]
`timescale 1ns / 100ps

module tb_bracket_aware_token_skipper;
  import bats_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 5;
  localparam int TOKEN_TARGET = 800;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  // Classes the package leaves unnamed
  localparam logic [CLS_W-1:0] CLS_OPEN_BRACKET  = 3'd2;
  localparam logic [CLS_W-1:0] CLS_CLOSE_BRACKET = 3'd5;
  localparam logic [CLS_W-1:0] CLS_SPARE         = 3'd7;

  typedef enum int {SINK_STEADY, SINK_COIN, SINK_PATTERN, SINK_HOLD} sink_mode_t;
  typedef enum int {END_STOP, END_STREAM, END_FOREIGN, END_OVERFLOW, END_OPEN} run_end_t;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent       = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  bats_tok_if tok ();
  bats_res_if res ();

  bracket_aware_token_skipper dut (
    .clk (clk),
    .rst (rst),
    .tok (tok),
    .res (res)
  );

  nesting_checker u_nesting (
    .clk        (clk),
    .rst        (rst),
    .tok        (tok),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #CLK_HALF clk = ~clk;

  // Offer one token word in bursts with random gaps; return once it is taken
  task automatic send_token(input logic [CLS_W-1:0] cls, input logic stop,
                            input logic eos);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        tok.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    tok.valid         <= 1'b1;
    tok.bracket_class <= cls;
    tok.is_stop       <= stop;
    tok.end_of_stream <= eos;
    do @(posedge clk); while (!tok.ready);
    sent++;
  endtask

  // Result side: segments of steady, random, patterned or held-off ready
  initial begin : result_sink
    sink_mode_t mode;
    int         span;
    logic [7:0] mask;
    bit         first_hold;
    res.ready <= 1'b0;
    first_hold = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      case ($urandom_range(0, 7))
        0, 1, 2: mode = SINK_STEADY;
        3, 4:    mode = SINK_COIN;
        5, 6:    mode = SINK_PATTERN;
        default: mode = SINK_HOLD;
      endcase
      // hold off early on so the block backs up into the token side
      if (first_hold) begin
        mode = SINK_HOLD;
      end
      first_hold = 1'b0;
      span = (mode == SINK_HOLD) ? $urandom_range(40, 80) : $urandom_range(8, 60);
      mask = 8'($urandom_range(1, 255));
      for (int i = 0; i < span; i++) begin
        case (mode)
          SINK_STEADY:  res.ready <= 1'b1;
          SINK_COIN:    res.ready <= 1'($urandom_range(0, 1));
          SINK_PATTERN: res.ready <= mask[i % 8];
          default:      res.ready <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  // Stop the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (tok.valid && tok.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("bracket_aware_token_skipper regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    kind_t    shadow [STACK_DEPTH];
    int       depth;
    int       cap;
    int       pick;
    run_end_t ending;
    tok.valid         <= 1'b0;
    tok.bracket_class <= CLS_NONE;
    tok.is_stop       <= 1'b0;
    tok.end_of_stream <= 1'b0;
    rst               <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // single tokens at top level: spare class, stops, end of stream, stray closer
    send_token(CLS_SPARE, 1'b0, 1'b0);
    send_token(CLS_NONE, 1'b1, 1'b0);
    send_token(CLS_SPARE, 1'b1, 1'b1);
    send_token(CLS_CLOSE_PAREN, 1'b1, 1'b0);
    send_token(CLS_CLOSE_BRACE, 1'b0, 1'b0);

    // nest all three kinds, stop ignored inside, close the brace, then a mismatched closer
    send_token(CLS_OPEN_PAREN, 1'b0, 1'b0);
    send_token(CLS_OPEN_BRACKET, 1'b1, 1'b0);
    send_token(CLS_OPEN_BRACE, 1'b1, 1'b0);
    send_token(CLS_NONE, 1'b1, 1'b0);
    send_token(CLS_CLOSE_BRACE, 1'b1, 1'b0);
    send_token(CLS_CLOSE_PAREN, 1'b0, 1'b0);

    // end of stream with a bracket still open
    send_token(CLS_OPEN_BRACE, 1'b0, 1'b0);
    send_token(CLS_CLOSE_BRACE, 1'b0, 1'b1);

    // fill the stack to the top, then one opener too many
    for (int i = 0; i <= STACK_DEPTH; i++) begin
      send_token(CLS_OPEN_PAREN + CLS_W'(i % 3), 1'b0, 1'b0);
    end

    // random runs, mostly well nested, some ending badly, some pure noise
    while (sent < TOKEN_TARGET) begin
      if ($urandom_range(0, 19) < 3) begin
        repeat ($urandom_range(1, 8)) begin
          send_token(CLS_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 7) == 0);
        end
        // close the stream so the next run starts from an empty stack
        send_token(CLS_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        depth = 0;
        cap   = ($urandom_range(0, 9) == 0) ? STACK_DEPTH : $urandom_range(1, 6);
        repeat ($urandom_range(1, 30)) begin
          pick = $urandom_range(0, 9);
          if (pick < 4 && depth < cap) begin
            shadow[depth] = kind_t'($urandom_range(0, 2));
            send_token(CLS_OPEN_PAREN + shadow[depth],
                       depth > 0 && $urandom_range(0, 3) == 0, 1'b0);
            depth++;
          end else if (pick < 7 && depth > 0) begin
            depth--;
            send_token(CLS_CLOSE_PAREN + shadow[depth], 1'($urandom_range(0, 1)), 1'b0);
          end else begin
            // plain token; a stop only where it is ignored
            send_token($urandom_range(0, 1) ? CLS_NONE : CLS_SPARE,
                       depth > 0 && $urandom_range(0, 1) == 1, 1'b0);
          end
        end

        case ($urandom_range(0, 9))
          0, 1, 2: ending = END_STOP;
          3, 4:    ending = END_STREAM;
          5, 6:    ending = END_FOREIGN;
          7:       ending = END_OVERFLOW;
          default: ending = END_OPEN;
        endcase

        case (ending)
          END_STOP, END_OPEN: begin
            while (depth > 0) begin
              depth--;
              send_token(CLS_CLOSE_PAREN + shadow[depth], 1'($urandom_range(0, 1)), 1'b0);
            end
            if (ending == END_STOP) begin
              send_token(CLS_W'($urandom_range(0, 7)), 1'b1, 1'b0);
            end
          end
          END_STREAM: begin
            send_token(CLS_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'b1);
          end
          END_FOREIGN: begin
            if (depth > 0) begin
              send_token(CLS_CLOSE_PAREN +
                         kind_t'((shadow[depth-1] + $urandom_range(1, 2)) % 3),
                         1'($urandom_range(0, 1)), 1'b0);
            end else begin
              send_token(CLS_CLOSE_PAREN + kind_t'($urandom_range(0, 2)), 1'b0, 1'b0);
            end
          end
          default: begin
            while (depth < STACK_DEPTH) begin
              send_token(CLS_OPEN_PAREN + kind_t'($urandom_range(0, 2)),
                         depth > 0 && $urandom_range(0, 1) == 1, 1'b0);
              depth++;
            end
            send_token(CLS_OPEN_PAREN + kind_t'($urandom_range(0, 2)),
                       1'($urandom_range(0, 1)), 1'b0);
          end
        endcase
      end
    end
    tok.valid <= 1'b0;

    // drain the awaited words, then allow for the result latency
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("bracket_aware_token_skipper regression: pass");
    end else begin
      $display("bracket_aware_token_skipper regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/bats_pkg.sv
rtl/bats_if.sv
rtl/bats_cell.sv
rtl/bats_ctrl.sv
rtl/bracket_aware_token_skipper.sv
tb/nesting_checker.sv
tb/tb_bracket_aware_token_skipper.sv
